/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LBDM_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("lbdm assertion failed");

// next-cycle implication
`define LBDM_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("lbdm assertion failed");

`endif

/* rtl/lbdm_pkg.sv */
// ----------------------------------------------------------------------------
// lbdm_pkg
// types, constants and the response table of the brightness to duty mapper
// ----------------------------------------------------------------------------
package lbdm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DUTY_BITS = 12;
    localparam int LOG_FRAC  = 30;
    localparam int TAB_LAST  = 60;

    localparam logic [16:0] ONE_LEVEL = 17'h10000;
    localparam logic [23:0] ONE_BASE  = 24'h010000;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [12:0] FULL_DUTY = 13'h1000;

    // register indexes
    typedef enum logic [1:0] {
        REG_BASE_RED   = 2'd0,
        REG_BASE_WHITE = 2'd1,
        REG_BASE_BLUE  = 2'd2,
        REG_BASE_GREEN = 2'd3
    } reg_idx_t;

    // response curve, Q1.16
    localparam logic [16:0] RESP_TAB [61] = '{
        17'd0,     17'd575,   17'd1148,  17'd1709,  17'd2269,  17'd2839,
        17'd3428,  17'd4042,  17'd4688,  17'd5369,  17'd6089,  17'd6853,
        17'd7663,  17'd8525,  17'd9442,  17'd10420, 17'd11466, 17'd12584,
        17'd13782, 17'd15065, 17'd16440, 17'd17912, 17'd19484, 17'd21158,
        17'd22935, 17'd24812, 17'd26784, 17'd28844, 17'd30983, 17'd33188,
        17'd35444, 17'd37734, 17'd40039, 17'd42339, 17'd44612, 17'd46836,
        17'd48991, 17'd51056, 17'd53011, 17'd54840, 17'd56528, 17'd58065,
        17'd59442, 17'd60656, 17'd61707, 17'd62599, 17'd63339, 17'd63939,
        17'd64410, 17'd64770, 17'd65035, 17'd65222, 17'd65350, 17'd65432,
        17'd65481, 17'd65509, 17'd65524, 17'd65530, 17'd65532, 17'd65534,
        17'd65536
    };

    typedef logic [30:0] root_arr_t [LOG_FRAC];

    // floored integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = v_in;
        r  = 64'd0;
        bt = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // roots 2^(2^-k) in Q1.30 for k = 1 .. 30
    function automatic root_arr_t calc_roots();
        root_arr_t   arr;
        logic [63:0] root;
        root = isqrt64(64'd2 << 60);
        for (int k = 0; k < LOG_FRAC; k++) begin
            arr[k] = root[30:0];
            root   = isqrt64(root << LOG_FRAC);
        end
        return arr;
    endfunction

    localparam root_arr_t ROOTS = calc_roots();

    // log2 phase
    typedef struct packed {
        logic        vld;
        logic        byp;
        logic [16:0] d;
        logic [2:0]  lint;
        logic [30:0] m;
        logic [29:0] lfrac;
        logic [23:0] bm1;
    } log_t;

    // exp2 phase
    typedef struct packed {
        logic        vld;
        logic        byp;
        logic [16:0] d;
        logic [2:0]  xi;
        logic [29:0] xf;
        logic [30:0] r;
        logic [23:0] bm1;
    } exp_t;

    // division phase
    typedef struct packed {
        logic        vld;
        logic        byp;
        logic        sat;
        logic [16:0] d;
        logic [37:0] den;
        logic [37:0] rem;
        logic [11:0] q;
    } div_t;

endpackage

/* rtl/lbdm_front.sv */
// ----------------------------------------------------------------------------
// lbdm_front
// clamp, table interpolation and mantissa normalization, three stages
// ----------------------------------------------------------------------------
module lbdm_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_vld,
    input  logic [16:0]        level,
    input  logic [1:0]         channel,
    input  logic [23:0]        base [4],
    output lbdm_pkg::log_t     log_out
);

    typedef struct packed {
        logic        vld;
        logic        byp;
        logic [5:0]  idx;
        logic [15:0] f;
        logic [2:0]  lint;
        logic [30:0] m;
        logic [23:0] bm1;
    } pos_t;

    typedef struct packed {
        logic        vld;
        logic        byp;
        logic [16:0] t0;
        logic [16:0] diff;
        logic [15:0] f;
        logic [2:0]  lint;
        logic [30:0] m;
        logic [23:0] bm1;
    } tab_t;

    pos_t           s1_reg, s1_next;
    tab_t           s2_reg, s2_next;
    lbdm_pkg::log_t s3_reg, s3_next;

    logic [16:0] lvl_c;
    logic [22:0] pos;
    logic [23:0] b;
    logic [4:0]  msb;
    logic [30:0] b_wide;
    logic [5:0]  idx1;
    logic [32:0] prod;

    // stage 1: clamp, position, base select and leading one
    always_comb begin
        lvl_c = (level > lbdm_pkg::ONE_LEVEL) ? lbdm_pkg::ONE_LEVEL : level;
        pos   = {6'd0, lvl_c} * 23'd60;
        case (channel)
            2'd0:    b = base[0];
            2'd1:    b = base[1];
            2'd2:    b = base[2];
            2'd3:    b = base[3];
            default: b = base[0];
        endcase
        msb = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (b[i]) msb = 5'(i);
        end
        b_wide       = {7'd0, b};
        s1_next.vld  = in_vld;
        s1_next.byp  = (b <= lbdm_pkg::ONE_BASE);
        s1_next.idx  = pos[21:16];
        s1_next.f    = pos[15:0];
        s1_next.lint = 3'(msb - 5'd16);
        s1_next.m    = b_wide << (5'd30 - msb);
        s1_next.bm1  = b - lbdm_pkg::ONE_BASE;
    end

    // stage 2: table reads, last entry repeats at full level
    always_comb begin
        idx1         = (s1_reg.idx >= 6'(lbdm_pkg::TAB_LAST)) ?
                       6'(lbdm_pkg::TAB_LAST) : s1_reg.idx + 6'd1;
        s2_next.vld  = s1_reg.vld;
        s2_next.byp  = s1_reg.byp;
        s2_next.t0   = lbdm_pkg::RESP_TAB[s1_reg.idx];
        s2_next.diff = lbdm_pkg::RESP_TAB[idx1] - lbdm_pkg::RESP_TAB[s1_reg.idx];
        s2_next.f    = s1_reg.f;
        s2_next.lint = s1_reg.lint;
        s2_next.m    = s1_reg.m;
        s2_next.bm1  = s1_reg.bm1;
    end

    // stage 3: linear interpolation
    always_comb begin
        prod          = s2_reg.diff * s2_reg.f;
        s3_next.vld   = s2_reg.vld;
        s3_next.byp   = s2_reg.byp;
        s3_next.d     = s2_reg.t0 + prod[32:16];
        s3_next.lint  = s2_reg.lint;
        s3_next.m     = s2_reg.m;
        s3_next.lfrac = 30'd0;
        s3_next.bm1   = s2_reg.bm1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
            s2_reg.vld <= 1'b0;
            s3_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign log_out = s3_reg;

endmodule

/* rtl/lbdm_log_cell.sv */
// ----------------------------------------------------------------------------
// lbdm_log_cell
// one fraction bit of log2 by squaring the mantissa
// ----------------------------------------------------------------------------
module lbdm_log_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  lbdm_pkg::log_t c_in,
    output lbdm_pkg::log_t c_out
);

    lbdm_pkg::log_t q_reg, q_next;
    logic [61:0]    sq;
    logic [31:0]    sq_q30;

    // square, renormalize when the result reaches two
    always_comb begin
        sq      = c_in.m * c_in.m;
        sq_q30  = sq[61:30];
        q_next  = c_in;
        if (sq_q30[31]) begin
            q_next.m     = sq_q30[31:1];
            q_next.lfrac = {c_in.lfrac[28:0], 1'b1};
        end else begin
            q_next.m     = sq_q30[30:0];
            q_next.lfrac = {c_in.lfrac[28:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else if (adv) begin
            q_reg <= q_next;
        end
    end

    assign c_out = q_reg;

endmodule

/* rtl/lbdm_exp_cell.sv */
// ----------------------------------------------------------------------------
// lbdm_exp_cell
// one fraction bit of exp2 by a conditional multiply with a fixed root
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbdm_exp_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic [30:0]    root,
    input  lbdm_pkg::exp_t c_in,
    output lbdm_pkg::exp_t c_out
);

    lbdm_pkg::exp_t q_reg, q_next;
    logic [61:0]    prod;

    // multiply in the root when the leading fraction bit is set
    always_comb begin
        prod      = c_in.r * root;
        q_next    = c_in;
        q_next.xf = {c_in.xf[28:0], 1'b0};
        if (c_in.xf[29]) q_next.r = prod[60:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else if (adv) begin
            q_reg <= q_next;
        end
    end

    assign c_out = q_reg;

    // partial power stays within one to two
    `LBDM_ASSERT_IMP(a_exp_range, aclk, aresetn, q_reg.vld, q_reg.r[30])

endmodule

/* rtl/lbdm_div_cell.sv */
// ----------------------------------------------------------------------------
// lbdm_div_cell
// one quotient bit of restoring division
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbdm_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  lbdm_pkg::div_t c_in,
    output lbdm_pkg::div_t c_out
);

    lbdm_pkg::div_t q_reg, q_next;
    logic [38:0]    rem2;
    logic           ge;

    // shift remainder, subtract divisor when it fits
    always_comb begin
        rem2     = {c_in.rem, 1'b0};
        ge       = (rem2 >= {1'b0, c_in.den});
        q_next   = c_in;
        q_next.q = {c_in.q[10:0], ge};
        if (ge) q_next.rem = 38'(rem2 - {1'b0, c_in.den});
        else    q_next.rem = rem2[37:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else if (adv) begin
            q_reg <= q_next;
        end
    end

    assign c_out = q_reg;

    // remainder stays below the divisor on the corrected path
    `LBDM_ASSERT_IMP(a_div_rem, aclk, aresetn,
        q_reg.vld && !q_reg.byp && !q_reg.sat, q_reg.rem < q_reg.den)

endmodule

/* rtl/led_brightness_to_duty_mapper.sv */
// ----------------------------------------------------------------------------
// led_brightness_to_duty_mapper
// gamma table interpolation and per-channel camera correction to PWM duty
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the output is held, and returns the
// duties in order. The pipeline is made of three front stages, 30 log2
// squaring cells, one scaling multiply, 30 exp2 root cells, one divider setup
// stage, 12 divider cells and the output register. The whole pipeline holds
// while a result waits on m_ready. Base registers take effect for items
// accepted after the write; no clearing pass is needed.
`include "assert_macros.svh"

module led_brightness_to_duty_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [16:0] s_level,
    input  logic [1:0]  s_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [12:0] m_duty,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    localparam int NCELL = lbdm_pkg::LOG_FRAC;
    localparam int NDIV  = lbdm_pkg::DUTY_BITS;

    logic [23:0]    base_reg [4];
    logic           adv;
    lbdm_pkg::log_t log_chain [NCELL + 1];
    lbdm_pkg::exp_t exp_chain [NCELL + 1];
    lbdm_pkg::div_t div_chain [NDIV + 1];
    lbdm_pkg::exp_t x_reg, x_next;
    lbdm_pkg::div_t dp_reg, dp_next;
    logic           m_valid_reg;
    logic [12:0]    m_duty_reg;
    logic [12:0]    duty_next;
    logic [32:0]    log2_val;
    logic [49:0]    x_prod;
    logic [37:0]    p_val;
    logic [37:0]    num;

    // whole pipeline advances unless the output is held
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // base registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg[0] <= 24'd2119170;
            base_reg[1] <= 24'd591174;
            base_reg[2] <= 24'd1023450;
            base_reg[3] <= 24'd541793;
        end else if (cfg_we) begin
            case (lbdm_pkg::reg_idx_t'(cfg_index))
                lbdm_pkg::REG_BASE_RED:   base_reg[0] <= cfg_wdata;
                lbdm_pkg::REG_BASE_WHITE: base_reg[1] <= cfg_wdata;
                lbdm_pkg::REG_BASE_BLUE:  base_reg[2] <= cfg_wdata;
                lbdm_pkg::REG_BASE_GREEN: base_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lbdm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_valid),
        .level   (s_level),
        .channel (s_channel),
        .base    (base_reg),
        .log_out (log_chain[0])
    );

    // log2 chain
    for (genvar g = 0; g < NCELL; g++) begin : g_log
        lbdm_log_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .c_in    (log_chain[g]),
            .c_out   (log_chain[g + 1])
        );
    end

    // scale log2 by the interpolated level
    always_comb begin
        log2_val    = {log_chain[NCELL].lint, log_chain[NCELL].lfrac};
        x_prod      = log_chain[NCELL].d * log2_val;
        x_next.vld  = log_chain[NCELL].vld;
        x_next.byp  = log_chain[NCELL].byp;
        x_next.d    = log_chain[NCELL].d;
        x_next.xi   = x_prod[48:46];
        x_next.xf   = x_prod[45:16];
        x_next.r    = lbdm_pkg::ONE_Q30;
        x_next.bm1  = log_chain[NCELL].bm1;
    end

    assign exp_chain[0] = x_reg;

    // exp2 chain
    for (genvar g = 0; g < NCELL; g++) begin : g_exp
        lbdm_exp_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .root    (lbdm_pkg::ROOTS[g]),
            .c_in    (exp_chain[g]),
            .c_out   (exp_chain[g + 1])
        );
    end

    // divider setup and saturation check
    always_comb begin
        p_val        = 38'(exp_chain[NCELL].r) << exp_chain[NCELL].xi;
        num          = p_val - 38'(lbdm_pkg::ONE_Q30);
        dp_next.vld  = exp_chain[NCELL].vld;
        dp_next.byp  = exp_chain[NCELL].byp;
        dp_next.d    = exp_chain[NCELL].d;
        dp_next.den  = {exp_chain[NCELL].bm1, 14'd0};
        dp_next.sat  = (num >= {exp_chain[NCELL].bm1, 14'd0});
        dp_next.rem  = num;
        dp_next.q    = 12'd0;
    end

    assign div_chain[0] = dp_reg;

    // divider chain
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        lbdm_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .c_in    (div_chain[g]),
            .c_out   (div_chain[g + 1])
        );
    end

    // final duty select
    always_comb begin
        if (div_chain[NDIV].byp)      duty_next = div_chain[NDIV].d[16:4];
        else if (div_chain[NDIV].sat) duty_next = lbdm_pkg::FULL_DUTY;
        else                          duty_next = {1'b0, div_chain[NDIV].q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg.vld   <= 1'b0;
            dp_reg.vld  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            x_reg       <= x_next;
            dp_reg      <= dp_next;
            m_valid_reg <= div_chain[NDIV].vld;
            m_duty_reg  <= duty_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_duty  = m_duty_reg;

    // duty never exceeds full scale
    `LBDM_ASSERT_IMP(a_duty_max, aclk, aresetn, m_valid_reg,
        m_duty_reg <= lbdm_pkg::FULL_DUTY)

    // a result held back by m_ready stays valid, keeping the input side stalled
    `LBDM_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_valid_reg && !m_ready,
        m_valid_reg)

endmodule
